// File: hdl/kavf_pkg.sv
// kavf_pkg: shared types, codes and helpers for the altitude/velocity kalman filter
// no dependencies
package kavf_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_PH,
        OP_P0,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_P5,
        OP_U0,
        OP_U1,
        OP_U2,
        OP_U3,
        OP_U4,
        OP_U5
    } op_t;

    localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [1:0] CFG_POS_NOISE   = 2'd1;
    localparam logic [1:0] CFG_VEL_NOISE   = 2'd2;
    localparam logic [1:0] CFG_MEAS_NOISE  = 2'd3;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    typedef struct packed {
        logic               done;
        logic signed [69:0] product;
    } mul_res_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } div_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > 56'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -56'sh0000_0000_8000_0000)
        begin
            r = -32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/kavf_mul.sv
// kavf_mul: shared signed multiplier, 36 x 34 bits in two passes of 36 x 18
// depends on kavf_pkg
module kavf_mul
    import kavf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [35:0] a,
    input  logic signed [33:0] b,
    output mul_res_t           res
);

    logic               phase_reg;
    logic               done_reg;
    logic signed [53:0] lo_reg;
    logic signed [69:0] product_reg;
    logic signed [17:0] b_part;
    logic signed [53:0] part;

    // low pass takes the unsigned low 17 bits, high pass the signed upper 17
    assign b_part = phase_reg ? $signed({b[33], b[33:17]}) : $signed({1'b0, b[16:0]});
    assign part   = a * b_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= start;
            done_reg  <= phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= part;
        end
        if (phase_reg)
        begin
            product_reg <= 70'(lo_reg) + (70'(part) <<< 17);
        end
    end

    assign res.done    = done_reg;
    assign res.product = product_reg;

endmodule

// File: hdl/kavf_div.sv
// kavf_div: iterative restoring divider for the gains, one quotient bit a cycle
// depends on kavf_pkg
module kavf_div
    import kavf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] num,
    input  logic signed [33:0] den,
    output div_res_t           res
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] n_reg;
    logic [33:0] d_reg;
    logic [34:0] rem_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic signed [31:0] q_reg;

    logic [34:0] rem_sh;
    logic        ge;
    logic [47:0] n_final;
    logic signed [31:0] q_sat;

    assign rem_sh  = {rem_reg[33:0], n_reg[47]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign n_final = {n_reg[46:0], ge};

    always_comb
    begin
        if (zero_reg)
        begin
            q_sat = '0;
        end
        else if (!neg_reg)
        begin
            q_sat = (n_final > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(n_final[31:0]);
        end
        else
        begin
            q_sat = (n_final > 48'h0000_8000_0000) ? -32'sh8000_0000
                                                   : $signed(~n_final[31:0] + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd47;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= num[47] ? 48'(-num) : 48'(num);
            d_reg    <= den[33] ? 34'(-den) : 34'(den);
            rem_reg  <= '0;
            neg_reg  <= num[47] ^ den[33];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            n_reg   <= n_final;
            if (cnt_reg == 6'd0)
            begin
                q_reg <= q_sat;
            end
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = q_reg;

    busy_done_a: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

// File: hdl/kalman_altitude_velocity_filter_top.sv
// Two-state kalman filter (position, velocity) in signed Q16.16. A predict step
// (tuser 0, tdata acceleration) runs seven products through the shared two-pass
// multiplier. An update step (tuser 1, tdata measured position) runs two gain
// divisions in the 48-step divider, then six products. One item is in work at a time;
// the result sits in an output register while the next item may be accepted.
// depends on kavf_pkg, kavf_mul, kavf_div
module kalman_altitude_velocity_filter_top
    import kavf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_value
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // position_estimate, velocity_estimate
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   issued_reg, issued_next;
    logic   dsel_reg, dsel_next;

    logic [16:0] dt_reg;
    logic [30:0] pn_reg, vn_reg, r_reg;

    logic signed [31:0] x0_reg, x0_next, x1_reg, x1_next;
    logic signed [31:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next, p11_reg, p11_next;

    logic signed [31:0] v_reg, v_next;
    logic signed [32:0] y_reg, y_next;
    logic signed [33:0] s_reg, s_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic [16:0]        h_reg, h_next;
    logic signed [35:0] dp_reg, dp_next;
    logic signed [55:0] acc_reg, acc_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    logic               mul_start, div_start;
    logic signed [35:0] mul_a;
    logic signed [33:0] mul_b;
    mul_res_t           mul_res;
    div_res_t           div_res;
    logic signed [47:0] div_num;

    logic signed [53:0] q;
    logic signed [55:0] qe;
    logic signed [33:0] dt_b;
    logic signed [55:0] pn_e, vn_e, dp_e;

    assign q    = $signed(mul_res.product[69:16]);
    assign qe   = 56'(q);
    assign dt_b = $signed({17'b0, dt_reg});
    assign pn_e = $signed({25'b0, pn_reg});
    assign vn_e = $signed({25'b0, vn_reg});
    assign dp_e = 56'(dp_reg);

    assign div_num = $signed({(dsel_reg ? p10_reg : p00_reg), 16'b0});

    kavf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .res   (mul_res)
    );

    kavf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .res   (div_res)
    );

    // operand select
    always_comb
    begin
        mul_a = 36'(x1_reg);
        mul_b = dt_b;
        case (op_reg)
            OP_PH:
            begin
                mul_a = $signed({19'b0, dt_reg});
                mul_b = dt_b;
            end
            OP_P0: mul_a = 36'(p11_reg);
            OP_P1: mul_a = 36'(x1_reg);
            OP_P2:
            begin
                mul_a = 36'(v_reg);
                mul_b = $signed({17'b0, h_reg});
            end
            OP_P3: mul_a = 36'(v_reg);
            OP_P4: mul_a = 36'(p10_reg);
            OP_P5: mul_a = 36'(p01_reg) + dp_reg;
            OP_U0:
            begin
                mul_a = 36'(y_reg);
                mul_b = 34'(k0_reg);
            end
            OP_U1:
            begin
                mul_a = 36'(y_reg);
                mul_b = 34'(k1_reg);
            end
            OP_U2:
            begin
                mul_a = 36'(p00_reg);
                mul_b = 34'(k1_reg);
            end
            OP_U3:
            begin
                mul_a = 36'(p00_reg);
                mul_b = 34'(k0_reg);
            end
            OP_U4:
            begin
                mul_a = 36'(p01_reg);
                mul_b = 34'(k1_reg);
            end
            OP_U5:
            begin
                mul_a = 36'(p01_reg);
                mul_b = 34'(k0_reg);
            end
            default:
            begin
                mul_a = 36'(x1_reg);
                mul_b = dt_b;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        issued_next  = issued_reg;
        dsel_next    = dsel_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        p00_next     = p00_reg;
        p01_next     = p01_reg;
        p10_next     = p10_reg;
        p11_next     = p11_reg;
        v_next       = v_reg;
        y_next       = y_reg;
        s_next       = s_reg;
        k0_next      = k0_reg;
        k1_next      = k1_reg;
        h_next       = h_reg;
        dp_next      = dp_reg;
        acc_next     = acc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        s_tready     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    v_next      = $signed(s_tdata);
                    y_next      = 33'($signed(s_tdata)) - 33'(x0_reg);
                    s_next      = 34'(p00_reg) + $signed({3'b0, r_reg});
                    issued_next = 1'b0;
                    dsel_next   = 1'b0;
                    if (s_tuser)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        op_next    = OP_PH;
                    end
                end
            end
            S_DIV:
            begin
                if (!issued_reg)
                begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (div_res.done)
                begin
                    issued_next = 1'b0;
                    if (!dsel_reg)
                    begin
                        k0_next   = div_res.quotient;
                        dsel_next = 1'b1;
                    end
                    else
                    begin
                        k1_next    = div_res.quotient;
                        op_next    = OP_U0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_res.done)
                begin
                    issued_next = 1'b0;
                    op_next     = op_t'(op_reg + 4'd1);
                    case (op_reg)
                        OP_PH: h_next = mul_res.product[33:17];
                        OP_P0: dp_next = q[35:0];
                        OP_P1: acc_next = 56'(x0_reg) + qe;
                        OP_P2: x0_next = sat32(acc_reg + qe);
                        OP_P3: x1_next = sat32(56'(x1_reg) + qe);
                        OP_P4: acc_next = 56'(p00_reg) + pn_e + qe;
                        OP_P5:
                        begin
                            p00_next   = sat32(acc_reg + qe);
                            p01_next   = sat32(56'(p01_reg) + dp_e);
                            p10_next   = sat32(56'(p10_reg) + dp_e);
                            p11_next   = sat32(56'(p11_reg) + vn_e);
                            state_next = S_OUT;
                        end
                        OP_U0: x0_next = sat32(56'(x0_reg) + qe);
                        OP_U1: x1_next = sat32(56'(x1_reg) + qe);
                        OP_U2: p10_next = sat32(56'(p10_reg) - qe);
                        OP_U3: p00_next = sat32(56'(p00_reg) - qe);
                        OP_U4: p11_next = sat32(56'(p11_reg) - qe);
                        OP_U5:
                        begin
                            p01_next   = sat32(56'(p01_reg) - qe);
                            state_next = S_OUT;
                        end
                        default: acc_next = acc_reg;
                    endcase
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = {x1_reg, x0_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_PH;
            issued_reg  <= 1'b0;
            dsel_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            dt_reg      <= 17'd655;
            pn_reg      <= 31'd66;
            vn_reg      <= 31'd66;
            r_reg       <= 31'd65536;
            x0_reg      <= '0;
            x1_reg      <= '0;
            p00_reg     <= Q_ONE;
            p01_reg     <= '0;
            p10_reg     <= '0;
            p11_reg     <= Q_ONE;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            issued_reg  <= issued_next;
            dsel_reg    <= dsel_next;
            m_valid_reg <= m_valid_next;
            x0_reg      <= x0_next;
            x1_reg      <= x1_next;
            p00_reg     <= p00_next;
            p01_reg     <= p01_next;
            p10_reg     <= p10_next;
            p11_reg     <= p11_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:  dt_reg <= cfg_data[16:0];
                    CFG_POS_NOISE:  pn_reg <= cfg_data;
                    CFG_VEL_NOISE:  vn_reg <= cfg_data;
                    CFG_MEAS_NOISE: r_reg  <= cfg_data;
                    default:        dt_reg <= dt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        y_reg      <= y_next;
        s_reg      <= s_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        h_reg      <= h_next;
        dp_reg     <= dp_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    accept_leaves_idle_a: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != S_IDLE)
        else $error("transfer accepted but sequencer stayed idle");

    mul_done_in_mul_a: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res.done |-> state_reg == S_MUL && issued_reg)
        else $error("multiplier result outside a multiply step");

    div_done_in_div_a: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV && issued_reg)
        else $error("divider result outside a division step");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for kalman_altitude_velocity_filter_top
// runs directed and random predict/update transfers through several register settings
// depends on kavf_pkg and the filter rtl
module tb_top;
    import kavf_pkg::*;

    localparam bit OPER_PREDICT = 1'b0;
    localparam bit OPER_UPDATE  = 1'b1;
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        bit                 op;
        logic signed [31:0] val;
        bit                 known;
        logic signed [31:0] exp_pos;
        logic signed [31:0] exp_vel;
    } sample_row_t;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } estimate_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    estimate_t expected_estimates[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;

    longint dt_q, pos_noise_q, vel_noise_q, meas_noise_q;
    longint est_pos, est_vel, p00, p01, p10, p11;

    sample_row_t directed_rows[10] = '{
        '{OPER_PREDICT, 32'sd0, 1'b1, 32'sd0, 32'sd0},
        '{OPER_UPDATE, 32'sd0, 1'b1, 32'sd0, 32'sd0},
        '{OPER_PREDICT, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
        '{OPER_PREDICT, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0},
        '{OPER_UPDATE, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
        '{OPER_UPDATE, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0},
        '{OPER_PREDICT, -32'sd65536, 1'b0, 32'sd0, 32'sd0},
        '{OPER_UPDATE, 32'sd65536, 1'b0, 32'sd0, 32'sd0},
        '{OPER_UPDATE, -32'sd1, 1'b0, 32'sd0, 32'sd0},
        '{OPER_PREDICT, 32'sd1, 1'b0, 32'sd0, 32'sd0}
    };

    kalman_altitude_velocity_filter_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qprod(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint kgain(input longint num, input longint den);
        if (den == 0)
        begin
            return 0;
        end
        return clamp32((num * 65536) / den);
    endfunction

    function automatic estimate_t filter_step(input bit op, input logic signed [31:0] sample);
        longint a, h, dp11, y, s, k0, k1;
        longint x0, x1, o00, o01, o10, o11;
        estimate_t r;
        a = sample;
        x0 = est_pos;
        x1 = est_vel;
        o00 = p00;
        o01 = p01;
        o10 = p10;
        o11 = p11;
        if (op == OPER_PREDICT)
        begin
            h = (dt_q * dt_q) / 131072;
            dp11 = qprod(dt_q, o11);
            est_pos = clamp32(x0 + qprod(dt_q, x1) + qprod(h, a));
            est_vel = clamp32(x1 + qprod(dt_q, a));
            p00 = clamp32(o00 + qprod(dt_q, o10) + qprod(dt_q, o01 + dp11) + pos_noise_q);
            p01 = clamp32(o01 + dp11);
            p10 = clamp32(o10 + dp11);
            p11 = clamp32(o11 + vel_noise_q);
        end
        else
        begin
            y = a - x0;
            s = o00 + meas_noise_q;
            k0 = kgain(o00, s);
            k1 = kgain(o10, s);
            est_pos = clamp32(x0 + qprod(k0, y));
            est_vel = clamp32(x1 + qprod(k1, y));
            p00 = clamp32(o00 - qprod(k0, o00));
            p01 = clamp32(o01 - qprod(k0, o01));
            p10 = clamp32(o10 - qprod(k1, o00));
            p11 = clamp32(o11 - qprod(k1, o01));
        end
        r.pos = est_pos[31:0];
        r.vel = est_vel[31:0];
        return r;
    endfunction

    task automatic send_sample(input bit op, input logic signed [31:0] val,
                               input bit known, input estimate_t typed);
        estimate_t e;
        if (!calm && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= val;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        e = filter_step(op, val);
        if (known)
        begin
            e = typed;
        end
        expected_estimates.push_back(e);
    endtask

    // leaves cfg_we high; set_all drops it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_TIME_STEP:  dt_q = value[16:0];
            CFG_POS_NOISE:  pos_noise_q = value;
            CFG_VEL_NOISE:  vel_noise_q = value;
            CFG_MEAS_NOISE: meas_noise_q = value;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_sample(input bit op);
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom;
        end
        if (op == OPER_UPDATE)
        begin
            return est_pos[31:0] + $signed($urandom_range(0, 131072)) - 32'sd65536;
        end
        return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
    endfunction

    task automatic run_random(input int count);
        int n;
        int burst;
        bit op;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                op = 1'($urandom_range(0, 1));
                send_sample(op, pick_sample(op), 1'b0, '{0, 0});
                n++;
            end
            else
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                begin
                    send_sample(OPER_PREDICT, pick_sample(OPER_PREDICT), 1'b0, '{0, 0});
                end
                send_sample(OPER_UPDATE, pick_sample(OPER_UPDATE), 1'b0, '{0, 0});
                n += burst + 1;
            end
        end
    endtask

    task automatic set_all(input logic [30:0] ts, input logic [30:0] pn,
                           input logic [30:0] vn, input logic [30:0] mn);
        write_reg(CFG_TIME_STEP, ts);
        write_reg(CFG_POS_NOISE, pn);
        write_reg(CFG_VEL_NOISE, vn);
        write_reg(CFG_MEAS_NOISE, mn);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end

    // output transfer check
    always @(posedge clk)
    begin
        estimate_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_estimates.size() == 0)
            begin
                $display("%0t unexpected transfer: actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_estimates.pop_front();
                if (m_tdata[31:0] !== e.pos)
                begin
                    $display("%0t position: expected %h actual %h", $time, e.pos, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.vel)
                begin
                    $display("%0t velocity: expected %h actual %h", $time, e.vel,
                             m_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        dt_q = 655;
        pos_noise_q = 66;
        vel_noise_q = 66;
        meas_noise_q = 65536;
        est_pos = 0;
        est_vel = 0;
        p00 = 65536;
        p01 = 0;
        p10 = 0;
        p11 = 65536;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_sample(directed_rows[i].op, directed_rows[i].val, directed_rows[i].known,
                        '{directed_rows[i].exp_pos, directed_rows[i].exp_vel});
        end
        set_all(31'd655, 31'd66, 31'd66, 31'd65536);
        run_random(80);
        set_all(31'd65536, 31'd0, 31'd0, 31'd1);
        run_random(80);
        calm = 1'b1;
        set_all(31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_random(80);
        calm = 1'b0;
        // zero measurement noise drives the divisor to zero after one update
        set_all(31'h1_FFFF, 31'd1000, 31'd1000, 31'd0);
        run_random(80);
        set_all(31'd0, 31'd66, 31'd66, 31'd65536);
        run_random(80);
        set_all(31'($urandom_range(1, 65536)), 31'($urandom_range(0, 5000)),
                31'($urandom_range(0, 5000)), 31'($urandom_range(1, 200000)));
        run_random(100);
        set_all(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
        run_random(100);
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
